### design/mpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mpm_pkg;

	typedef enum logic [1:0] {
		ACT_PATTERN = 2'd0,
		ACT_BUILD   = 2'd1,
		ACT_TEXT    = 2'd2,
		ACT_FINISH  = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD,
		ST_TX_HIT,
		ST_TX_WR,
		ST_BR_RD,
		ST_BR_ACT,
		ST_BQ_RB,
		ST_BQ_RF,
		ST_BQ_RG,
		ST_BQ_RV,
		ST_BQ_RT,
		ST_BQ_ACT,
		ST_FP_RB,
		ST_FP_RV,
		ST_FP_RF,
		ST_FP_ADD,
		ST_RP_RP,
		ST_RP_RH,
		ST_RP_OUT,
		ST_FC
	} state_t;

	localparam int unsigned FIELD_WIDTH = 32;

endpackage
`default_nettype wire

### design/mpm_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface mpm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] symbol;
	logic       ends_pattern;

	modport source (output valid, action, symbol, ends_pattern, input ready);
	modport sink (input valid, action, symbol, ends_pattern, output ready);
endinterface

interface mpm_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  pattern_index;
	logic [31:0] match_count;
	logic        overflow;
	logic        last_of_run;

	modport source (output valid, pattern_index, match_count, overflow, last_of_run,
		input ready);
	modport sink (input valid, pattern_index, match_count, overflow, last_of_run,
		output ready);
endinterface
`default_nettype wire

### design/multi_pattern_match_counter.sv
`timescale 1ns / 1ps
`default_nettype none
// Aho-Corasick occurrence counter.
// item channel: one word per command. Action pattern loads a byte into the trie,
// build makes failure links and completes the goto table, text steps the
// automaton (goto read, count read, count write), finish propagates counts up
// the failure tree, then reports.
// result channel: one word per loaded pattern in load order after finish, made
// one at a time (pattern node read, count read, output register); last_of_run
// marks the final word. After the report the counts are cleared.
// Every step is a read-modify-write on simple dual-port synchronous memories, so
// the block works on one command at a time; item.ready is high only when idle.
// A finished word waits in the output register; when the receiver stalls the
// report holds at that word, and a new command may be taken behind the last one.
// After reset all NODES*ALPHABET goto entries are cleared, one entry a cycle
// (hit counts alongside); item.ready stays low during that pass.
module multi_pattern_match_counter
	import mpm_pkg::*;
#(
	parameter int unsigned NODES        = 1024,
	parameter int unsigned MAX_PATTERNS = 64,
	parameter int unsigned ALPHABET     = 256,
	parameter int unsigned COUNT_WIDTH  = 32
) (
	input  wire    clk,
	input  wire    arst_n,
	mpm_in_if.sink     item,
	mpm_out_if.source  result
);
	localparam int unsigned NW  = $clog2(NODES);
	localparam int unsigned OW  = $clog2(NODES + 1);
	localparam int unsigned GD  = NODES * ALPHABET;
	localparam int unsigned GA  = $clog2(GD);
	localparam int unsigned SW  = $clog2(ALPHABET);
	localparam int unsigned PW  = $clog2(MAX_PATTERNS + 1);
	localparam int unsigned PA  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int unsigned CW  = COUNT_WIDTH;
	localparam int unsigned EW  = (CW > FIELD_WIDTH) ? CW : FIELD_WIDTH;

	function automatic logic [SW-1:0] sym_mod(input logic [7:0] s);
		logic [15:0] r;
		r = {8'd0, s};
		for (int k = 7; k >= 0; k--) begin
			if (r >= (16'(ALPHABET) << k)) begin
				r = r - (16'(ALPHABET) << k);
			end
		end
		return r[SW-1:0];
	endfunction

	function automatic logic [GA-1:0] gaddr(input logic [NW-1:0] n, input logic [SW-1:0] s);
		return GA'(n) * GA'(ALPHABET) + GA'(s);
	endfunction

	state_t state_q, state_d;

	logic [GA-1:0]  clr_q;
	logic [NW-1:0]  node_total_q, cursor_q, u_q, f_q, v_q;
	logic [PW-1:0]  pat_total_q, ridx_q;
	logic [OW-1:0]  order_q, head_q, fidx_q;
	logic [SW-1:0]  sym_q, c_q;
	logic           ends_q, ovf_q, built_q, lost_q;
	logic [CW-1:0]  hv_q;

	logic           out_valid_q;
	logic [5:0]     out_idx_q;
	logic [31:0]    out_cnt_q;
	logic           out_ovf_q, out_last_q;

	// memory ports
	logic           g_we, g_re, fl_we, fl_re, h_we, h_re, b_we, b_re, p_we, p_re;
	logic [GA-1:0]  g_waddr, g_raddr;
	logic [NW-1:0]  g_wdata, g_rdata, fl_waddr, fl_wdata, fl_raddr, fl_rdata;
	logic [NW-1:0]  h_waddr, h_raddr, b_wdata, b_rdata, p_wdata, p_rdata;
	logic [NW-1:0]  b_waddr, b_raddr;
	logic [CW-1:0]  h_wdata, h_rdata;
	logic [PA-1:0]  p_waddr, p_raddr;

	logic           accept, out_free;
	action_t        act;
	logic           ld_end;
	logic [NW-1:0]  ld_node;
	logic           ld_new, ld_lose;
	logic [CW:0]    sum;
	logic [CW-1:0]  sat_sum;
	logic [EW-1:0]  cnt_ext;

	assign act      = action_t'(item.action);
	assign accept   = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || result.ready;

	// new node for a missing edge during loading
	assign ld_new  = (g_rdata == '0) && (node_total_q < NW'(NODES - 1));
	assign ld_lose = (g_rdata == '0) && !ld_new;

	assign sum     = {1'b0, h_rdata} + {1'b0, hv_q};
	assign sat_sum = sum[CW] ? '1 : sum[CW-1:0];
	assign cnt_ext = EW'(h_rdata);

	always_comb begin
		ld_end  = 1'b0;
		ld_node = cursor_q;
		if (state_q == ST_IDLE && accept && act == ACT_PATTERN && !built_q && lost_q) begin
			ld_end = item.ends_pattern;
		end else if (state_q == ST_LD) begin
			ld_end = ends_q;
			if (g_rdata != '0) begin
				ld_node = g_rdata;
			end else if (ld_new) begin
				ld_node = node_total_q + NW'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == GA'(GD - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					case (act)
						ACT_PATTERN: if (!built_q && !lost_q) state_d = ST_LD;
						ACT_BUILD:   if (!built_q) state_d = ST_BR_RD;
						ACT_TEXT:    if (built_q) state_d = ST_TX_HIT;
						ACT_FINISH: begin
							if (built_q && order_q != '0) state_d = ST_FP_RB;
							else if (pat_total_q != '0) state_d = ST_RP_RP;
							else state_d = ST_FC;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LD:     state_d = ST_IDLE;
			ST_TX_HIT: state_d = ST_TX_WR;
			ST_TX_WR:  state_d = ST_IDLE;
			ST_BR_RD:  state_d = ST_BR_ACT;
			ST_BR_ACT: state_d = (c_q == SW'(ALPHABET - 1)) ? ST_BQ_RB : ST_BR_RD;
			ST_BQ_RB:  state_d = (head_q == order_q) ? ST_IDLE : ST_BQ_RF;
			ST_BQ_RF:  state_d = ST_BQ_RG;
			ST_BQ_RG:  state_d = ST_BQ_RV;
			ST_BQ_RV:  state_d = ST_BQ_RT;
			ST_BQ_RT:  state_d = ST_BQ_ACT;
			ST_BQ_ACT: state_d = (c_q == SW'(ALPHABET - 1)) ? ST_BQ_RB : ST_BQ_RV;
			ST_FP_RB:  state_d = ST_FP_RV;
			ST_FP_RV:  state_d = ST_FP_RF;
			ST_FP_RF:  state_d = ST_FP_ADD;
			ST_FP_ADD: begin
				if (fidx_q != OW'(1)) state_d = ST_FP_RB;
				else if (pat_total_q != '0) state_d = ST_RP_RP;
				else state_d = ST_FC;
			end
			ST_RP_RP:  state_d = ST_RP_RH;
			ST_RP_RH:  state_d = ST_RP_OUT;
			ST_RP_OUT: begin
				if (out_free) state_d = (ridx_q + PW'(1) == pat_total_q) ? ST_FC : ST_RP_RP;
			end
			ST_FC:     if (clr_q == GA'(NODES - 1)) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		g_we = 1'b0; g_waddr = gaddr(cursor_q, sym_q); g_wdata = '0;
		g_re = 1'b0; g_raddr = gaddr(cursor_q, sym_q);
		fl_we = 1'b0; fl_waddr = g_rdata; fl_wdata = '0;
		fl_re = 1'b0; fl_raddr = b_rdata;
		h_we = 1'b0; h_waddr = cursor_q; h_wdata = '0;
		h_re = 1'b0; h_raddr = g_rdata;
		b_we = 1'b0; b_waddr = order_q[NW-1:0]; b_wdata = g_rdata;
		b_re = 1'b0; b_raddr = head_q[NW-1:0];
		p_we = 1'b0; p_waddr = pat_total_q[PA-1:0]; p_wdata = ld_node;
		p_re = 1'b0; p_raddr = ridx_q[PA-1:0];
		p_we = ld_end && (pat_total_q < PW'(MAX_PATTERNS));
		case (state_q)
			ST_CLEAR: begin
				g_we = 1'b1; g_waddr = clr_q;
				h_we = (clr_q < GA'(NODES)); h_waddr = clr_q[NW-1:0];
			end
			ST_IDLE: begin
				g_re = accept && (act == ACT_PATTERN || act == ACT_TEXT);
				g_raddr = gaddr(cursor_q, sym_mod(item.symbol));
			end
			ST_LD: begin
				g_we = ld_new; g_wdata = node_total_q + NW'(1);
			end
			ST_TX_HIT: h_re = 1'b1;
			ST_TX_WR: begin
				h_we = 1'b1;
				h_wdata = (h_rdata == '1) ? h_rdata : h_rdata + CW'(1);
			end
			ST_BR_RD: begin
				g_re = 1'b1; g_raddr = gaddr('0, c_q);
			end
			ST_BR_ACT: begin
				fl_we = (g_rdata != '0) && (order_q < OW'(NODES));
				b_we = fl_we;
			end
			ST_BQ_RB: b_re = (head_q != order_q);
			ST_BQ_RF: fl_re = 1'b1;
			ST_BQ_RV: begin
				g_re = 1'b1; g_raddr = gaddr(u_q, c_q);
			end
			ST_BQ_RT: begin
				g_re = 1'b1; g_raddr = gaddr(f_q, c_q);
			end
			ST_BQ_ACT: begin
				// absent edge takes the failure target's move
				g_we = (v_q == '0); g_waddr = gaddr(u_q, c_q); g_wdata = g_rdata;
				fl_we = (v_q != '0) && (order_q < OW'(NODES));
				fl_waddr = v_q; fl_wdata = g_rdata;
				b_we = fl_we; b_wdata = v_q;
			end
			ST_FP_RB: begin
				b_re = 1'b1; b_raddr = NW'(fidx_q - OW'(1));
			end
			ST_FP_RV: begin
				fl_re = 1'b1; fl_raddr = b_rdata;
				h_re = 1'b1; h_raddr = b_rdata;
			end
			ST_FP_RF: begin
				h_re = 1'b1; h_raddr = fl_rdata;
			end
			ST_FP_ADD: begin
				h_we = 1'b1; h_waddr = f_q; h_wdata = sat_sum;
			end
			ST_RP_RP: p_re = 1'b1;
			ST_RP_RH: begin
				h_re = 1'b1; h_raddr = p_rdata;
			end
			ST_FC: begin
				h_we = 1'b1; h_waddr = clr_q[NW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			node_total_q <= '0;
			pat_total_q <= '0;
			order_q <= '0;
			head_q <= '0;
			cursor_q <= '0;
			ovf_q <= 1'b0;
			built_q <= 1'b0;
			lost_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_RP_OUT && out_free) out_valid_q <= 1'b1;
			else if (result.valid && result.ready) out_valid_q <= 1'b0;
			if (ld_end && pat_total_q < PW'(MAX_PATTERNS)) begin
				pat_total_q <= pat_total_q + PW'(1);
			end
			if ((ld_end && pat_total_q >= PW'(MAX_PATTERNS)) || (state_q == ST_LD && ld_lose)) begin
				ovf_q <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + GA'(1);
				ST_IDLE: begin
					clr_q <= '0;
					if (accept) begin
						if (act == ACT_BUILD && !built_q) begin
							built_q <= 1'b1;
							order_q <= '0;
							head_q <= '0;
							c_q <= '0;
						end
						if (act == ACT_FINISH) begin
							fidx_q <= order_q;
							ridx_q <= '0;
						end
						if (ld_end) begin
							cursor_q <= '0;
							lost_q <= 1'b0;
						end
					end
				end
				ST_LD: begin
					if (ld_new) node_total_q <= node_total_q + NW'(1);
					if (ld_end) begin
						cursor_q <= '0;
						lost_q <= 1'b0;
					end else if (ld_lose) begin
						lost_q <= 1'b1;
					end else begin
						cursor_q <= ld_node;
					end
				end
				ST_TX_HIT: cursor_q <= g_rdata;
				ST_BR_ACT: begin
					if (b_we) order_q <= order_q + OW'(1);
					c_q <= c_q + SW'(1);
				end
				ST_BQ_RB: begin
					if (head_q == order_q) begin
						cursor_q <= '0;
						lost_q <= 1'b0;
					end
				end
				ST_BQ_RF: begin
					u_q <= b_rdata;
					head_q <= head_q + OW'(1);
					c_q <= '0;
				end
				ST_BQ_RG: f_q <= fl_rdata;
				ST_BQ_RT: v_q <= g_rdata;
				ST_BQ_ACT: begin
					if (b_we) order_q <= order_q + OW'(1);
					c_q <= c_q + SW'(1);
				end
				ST_FP_RF: begin
					f_q <= fl_rdata;
					hv_q <= h_rdata;
				end
				ST_FP_ADD: fidx_q <= fidx_q - OW'(1);
				ST_RP_OUT: begin
					if (out_free) begin
						ridx_q <= ridx_q + PW'(1);
					end
				end
				ST_FC: begin
					clr_q <= clr_q + GA'(1);
					if (clr_q == GA'(NODES - 1)) cursor_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			sym_q <= sym_mod(item.symbol);
			ends_q <= item.ends_pattern;
		end
		if (state_q == ST_RP_OUT && out_free) begin
			out_idx_q <= 6'(ridx_q);
			out_cnt_q <= (cnt_ext > EW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cnt_ext[31:0];
			out_ovf_q <= ovf_q;
			out_last_q <= (ridx_q + PW'(1) == pat_total_q);
		end
	end

	assign result.valid         = out_valid_q;
	assign result.pattern_index = out_idx_q;
	assign result.match_count   = out_cnt_q;
	assign result.overflow      = out_ovf_q;
	assign result.last_of_run   = out_last_q;

	mpm_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
		.re(g_re), .raddr(g_raddr), .rdata(g_rdata));
	mpm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_fail (
		.clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
		.re(fl_re), .raddr(fl_raddr), .rdata(fl_rdata));
	mpm_ram #(.WIDTH(CW), .DEPTH(NODES)) u_hit (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata));
	mpm_ram #(.WIDTH(NW), .DEPTH(NODES)) u_bfs (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.re(b_re), .raddr(b_raddr), .rdata(b_rdata));
	mpm_ram #(.WIDTH(NW), .DEPTH(MAX_PATTERNS)) u_pend (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.re(p_re), .raddr(p_raddr), .rdata(p_rdata));

`ifndef SYNTHESIS
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !item.ready)
		else $error("command taken during clearing pass");
	a_node_bound: assert property (@(posedge clk) disable iff (!arst_n)
		node_total_q <= NW'(NODES - 1))
		else $error("node count beyond limit");
	a_pattern_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pat_total_q <= PW'(MAX_PATTERNS))
		else $error("pattern count beyond limit");
	a_word_from_report: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RP_OUT))
		else $error("result word outside report");
`endif
endmodule
`default_nettype wire

### design/mpm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mpm_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 1024
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                       wdata,
	input  wire                                   re,
	input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### bench/mpm_match_checker.sv
`timescale 1ns / 1ps
module mpm_match_checker
	import mpm_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	mpm_in_if    watch_in,
	mpm_out_if   watch_out,
	output int   errors,
	output int   pending,
	output int   words_seen
);

	localparam int N_NODES = 1024;
	localparam int N_SLOTS = 64;
	localparam int N_SYMS  = 256;

	typedef struct packed {
		logic [5:0]  pattern_index;
		logic [31:0] match_count;
		logic        overflow;
		logic        last_of_run;
	} count_word_t;

	bit [9:0]  trie_next [0:N_NODES*N_SYMS-1];
	bit [9:0]  fail_of [0:N_NODES-1];
	bit [31:0] node_hits [0:N_NODES-1];
	bit [9:0]  walk_order [0:N_NODES-1];
	bit [9:0]  slot_node [0:N_SLOTS-1];
	int        node_used, slots_used, walk_len;
	bit [9:0]  here;
	bit        ovf_seen, is_built, pattern_dropped;

	count_word_t counts_due[$];

	function automatic void add_pattern_byte(bit [7:0] sym, bit last);
		bit [9:0] nx;
		if (is_built)
			return;
		if (!pattern_dropped) begin
			nx = trie_next[here * N_SYMS + sym];
			if (nx == 0) begin
				if (node_used >= N_NODES - 1) begin
					ovf_seen = 1'b1;
					pattern_dropped = 1'b1;
				end else begin
					node_used++;
					nx = node_used[9:0];
					trie_next[here * N_SYMS + sym] = nx;
				end
			end
			if (!pattern_dropped)
				here = nx;
		end
		if (last) begin
			if (slots_used < N_SLOTS) begin
				slot_node[slots_used] = here;
				slots_used++;
			end else begin
				ovf_seen = 1'b1;
			end
			here = '0;
			pattern_dropped = 1'b0;
		end
	endfunction

	function automatic void link_automaton();
		int head, tail, c;
		bit [9:0] u, f, v, t;
		if (is_built)
			return;
		is_built = 1'b1;
		head = 0;
		tail = 0;
		for (c = 0; c < N_SYMS; c++) begin
			v = trie_next[c];
			if (v != 0 && tail < N_NODES) begin
				fail_of[v] = '0;
				walk_order[tail] = v;
				tail++;
			end
		end
		while (head < tail) begin
			u = walk_order[head];
			head++;
			f = fail_of[u];
			for (c = 0; c < N_SYMS; c++) begin
				v = trie_next[u * N_SYMS + c];
				t = trie_next[f * N_SYMS + c];
				if (v == 0) begin
					trie_next[u * N_SYMS + c] = t;
				end else if (tail < N_NODES) begin
					fail_of[v] = t;
					walk_order[tail] = v;
					tail++;
				end
			end
		end
		walk_len = tail;
		here = '0;
		pattern_dropped = 1'b0;
	endfunction

	function automatic void step_text(bit [7:0] sym);
		if (!is_built)
			return;
		here = trie_next[here * N_SYMS + sym];
		if (node_hits[here] != 32'hFFFF_FFFF)
			node_hits[here]++;
	endfunction

	function automatic void report_counts();
		int i;
		bit [9:0] v, f;
		bit [32:0] sum;
		count_word_t w;
		for (i = walk_len; i > 0; i--) begin
			v = walk_order[i - 1];
			f = fail_of[v];
			sum = {1'b0, node_hits[f]} + node_hits[v];
			node_hits[f] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
		for (i = 0; i < slots_used && i < N_SLOTS; i++) begin
			w.pattern_index = i[5:0];
			w.match_count = node_hits[slot_node[i]];
			w.overflow = ovf_seen;
			w.last_of_run = (i + 1 == slots_used);
			counts_due.push_back(w);
		end
		foreach (node_hits[k])
			node_hits[k] = '0;
		here = '0;
	endfunction

	initial begin
		errors = 0;
		pending = 0;
		words_seen = 0;
		node_used = 0;
		slots_used = 0;
		walk_len = 0;
		here = '0;
		ovf_seen = 1'b0;
		is_built = 1'b0;
		pattern_dropped = 1'b0;
	end

	always @(posedge clk) begin
		count_word_t want;
		if (arst_n) begin
			if (watch_in.valid && watch_in.ready) begin
				case (action_t'(watch_in.action))
					ACT_PATTERN: add_pattern_byte(watch_in.symbol, watch_in.ends_pattern);
					ACT_BUILD:   link_automaton();
					ACT_TEXT:    step_text(watch_in.symbol);
					default:     report_counts();
				endcase
			end
			if (watch_out.valid && watch_out.ready) begin
				words_seen++;
				if (counts_due.size() == 0) begin
					errors++;
					$display("%t: unexpected count word idx=%0d count=%0d", $time,
						watch_out.pattern_index, watch_out.match_count);
				end else begin
					want = counts_due.pop_front();
					if (watch_out.pattern_index !== want.pattern_index) begin
						errors++;
						$display("%t: pattern_index expected %0d got %0d", $time,
							want.pattern_index, watch_out.pattern_index);
					end
					if (watch_out.match_count !== want.match_count) begin
						errors++;
						$display("%t: match_count (idx %0d) expected %0d got %0d", $time,
							want.pattern_index, want.match_count, watch_out.match_count);
					end
					if (watch_out.overflow !== want.overflow) begin
						errors++;
						$display("%t: overflow expected %0b got %0b", $time,
							want.overflow, watch_out.overflow);
					end
					if (watch_out.last_of_run !== want.last_of_run) begin
						errors++;
						$display("%t: last_of_run expected %0b got %0b", $time,
							want.last_of_run, watch_out.last_of_run);
					end
				end
			end
			pending = counts_due.size();
		end
	end

endmodule

### bench/tb_multi_pattern_match_counter.sv
`timescale 1ns / 1ps
module tb_multi_pattern_match_counter;
	import mpm_pkg::*;

	logic clk;
	logic arst_n;
	int   errors, pending, words_seen;
	int   items_sent, finishes_sent;
	int   rx_wait;
	bit [7:0] pick_set [0:4] = '{8'h00, 8'hFF, 8'h61, 8'h62, 8'h63};

	mpm_in_if  item_ch ();
	mpm_out_if result_ch ();

	multi_pattern_match_counter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	mpm_match_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.watch_in   (item_ch),
		.watch_out  (result_ch),
		.errors     (errors),
		.pending    (pending),
		.words_seen (words_seen)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random gaps, gap-free stretches, and one long hold mid-report
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			rx_wait <= 0;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			if (rx_wait == 1)
				result_ch.ready <= 1'b1;
		end else if (!result_ch.ready) begin
			result_ch.ready <= 1'b1;
		end else if (result_ch.valid) begin
			if (words_seen == 10)
				g = 400;
			else if ((words_seen / 40) % 3 == 2)
				g = 0;
			else
				g = $urandom_range(0, 3);
			if (g > 0) begin
				result_ch.ready <= 1'b0;
				rx_wait <= g;
			end
		end
	end

	task automatic send_word(action_t act, bit [7:0] sym, bit last);
		int g;
		g = ((items_sent / 30) % 4 == 3) ? 0 : $urandom_range(0, 3);
		if (g > 0) begin
			item_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= act;
		item_ch.symbol <= sym;
		item_ch.ends_pattern <= last;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		if (act == ACT_FINISH)
			finishes_sent++;
	endtask

	function automatic bit [7:0] draw_symbol(int full_pct);
		if ($urandom_range(0, 99) < full_pct)
			return $urandom_range(0, 255);
		return pick_set[$urandom_range(0, 4)];
	endfunction

	task automatic load_pattern(int len);
		for (int i = 0; i < len; i++)
			send_word(ACT_PATTERN, draw_symbol(10), i == len - 1);
	endtask

	task automatic drain_reports();
		repeat (2) @(posedge clk);
		wait (pending == 0);
	endtask

	initial begin
		int r;
		items_sent = 0;
		finishes_sent = 0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = ACT_PATTERN;
		item_ch.symbol = '0;
		item_ch.ends_pattern = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored before build, and finish with nothing loaded
		send_word(ACT_TEXT, 8'h61, 1'b0);
		send_word(ACT_FINISH, 8'h00, 1'b0);
		send_word(ACT_PATTERN, 8'h00, 1'b1);
		send_word(ACT_PATTERN, 8'hFF, 1'b1);
		send_word(ACT_PATTERN, 8'h00, 1'b0);
		send_word(ACT_PATTERN, 8'hFF, 1'b0);
		send_word(ACT_PATTERN, 8'h00, 1'b1);
		send_word(ACT_PATTERN, 8'h61, 1'b0);
		send_word(ACT_PATTERN, 8'h62, 1'b1);
		// counts as held before build
		send_word(ACT_FINISH, 8'h00, 1'b0);
		drain_reports();

		while (u_checker.slots_used < 60)
			load_pattern($urandom_range(1, 3));
		// fill past the last slot with one-byte repeats
		repeat (6) send_word(ACT_PATTERN, 8'h62, 1'b1);
		// left open when the build comes
		send_word(ACT_PATTERN, 8'h63, 1'b0);
		send_word(ACT_PATTERN, 8'hA5, 1'b0);
		send_word(ACT_BUILD, 8'h00, 1'b0);
		send_word(ACT_PATTERN, 8'h61, 1'b1);
		send_word(ACT_BUILD, 8'h00, 1'b0);
		send_word(ACT_TEXT, 8'h00, 1'b0);
		send_word(ACT_TEXT, 8'hFF, 1'b0);
		send_word(ACT_TEXT, 8'h00, 1'b0);
		send_word(ACT_FINISH, 8'h00, 1'b0);

		while (items_sent < 410) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				send_word(ACT_FINISH, $urandom_range(0, 255), $urandom_range(0, 1));
				if (finishes_sent % 2 == 0)
					drain_reports();
			end else if (r < 8) begin
				send_word(r == 5 ? ACT_BUILD : ACT_PATTERN, $urandom_range(0, 255),
					$urandom_range(0, 1));
				items_sent--;
			end else begin
				send_word(ACT_TEXT, draw_symbol(15), $urandom_range(0, 1));
			end
		end
		send_word(ACT_FINISH, 8'h00, 1'b0);
		item_ch.valid <= 1'b0;

		drain_reports();
		repeat (2000) @(posedge clk);
		$display("Loaded %0d patterns, stepped text and reported %0d times over %0d commands;",
			u_checker.slots_used, finishes_sent, items_sent);
		$display("%0d count words checked, slot overflow and post-build ignores included.",
			words_seen);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
